/* hw/rtl/irpd_pkg.sv */
// ---------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants of the IR remote pulse decoder.
// ---------------------------------------------------------------------------
package irpd_pkg;

	localparam int unsigned DUR_W      = 15;
	localparam int unsigned CFG_W      = 15;
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned BITS_W     = 6;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned FRAME_BITS = 32;
	localparam int unsigned APB_AW     = 5;
	localparam int unsigned APB_DW     = 32;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [TIME_W-1:0] TICK_LIMIT  = 16'd30000;
	localparam logic [TIME_W-1:0] LONG_MIN_US = 16'd1200;
	localparam logic [TIME_W-1:0] LONG_MAX_US = 16'd2000;

	localparam logic [CFG_W-1:0] LEAD_MIN_RST   = 15'd8200;
	localparam logic [CFG_W-1:0] LEAD_MAX_RST   = 15'd9500;
	localparam logic [CFG_W-1:0] SPACE_MIN_RST  = 15'd4200;
	localparam logic [CFG_W-1:0] SPACE_MAX_RST  = 15'd4600;
	localparam logic [CFG_W-1:0] REP_MIN_RST    = 15'd2100;
	localparam logic [CFG_W-1:0] REP_MAX_RST    = 15'd2500;
	localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 15'd450;
	localparam logic [CFG_W-1:0] SHORT_MAX_RST  = 15'd600;

	typedef enum logic [2:0] {
		REG_LEAD_MIN  = 3'd0,
		REG_LEAD_MAX  = 3'd1,
		REG_SPACE_MIN = 3'd2,
		REG_SPACE_MAX = 3'd3,
		REG_REP_MIN   = 3'd4,
		REG_REP_MAX   = 3'd5,
		REG_SHORT_MIN = 3'd6,
		REG_SHORT_MAX = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_LEAD  = 5'b00010,
		PH_SPACE = 5'b00100,
		PH_MARK  = 5'b01000,
		PH_BIT   = 5'b10000
	} phase_t;

	// classified edge word handed from front to back
	typedef struct packed {
		logic clear;
		logic zero;
		logic lead_ok;
		logic space_ok;
		logic rep_ok;
		logic short_ok;
		logic long_ok;
	} cls_t;

endpackage

/* hw/rtl/irpd_if.sv */
// ---------------------------------------------------------------------------
// irpd_if
// Valid/ready channels of the IR remote pulse decoder.
// ---------------------------------------------------------------------------
interface irpd_in_if;
	import irpd_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [DUR_W-1:0]  duration;

	modport source(output valid, req_type, duration, input ready);
	modport sink(input valid, req_type, duration, output ready);
endinterface

interface irpd_out_if;
	import irpd_pkg::*;

	logic              valid;
	logic              ready;
	logic              frame_complete;
	logic              repeat_seen;
	logic [BYTE_W-1:0] address;
	logic [BYTE_W-1:0] command;
	logic              receiving;

	modport source(output valid, frame_complete, repeat_seen, address, command, receiving,
		input ready);
	modport sink(input valid, frame_complete, repeat_seen, address, command, receiving,
		output ready);
endinterface

/* hw/rtl/irpd_front.sv */
// ---------------------------------------------------------------------------
// irpd_front
// Register file and edge classifier: saturates the width and checks it
// against every window.
// ---------------------------------------------------------------------------
module irpd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [irpd_pkg::APB_AW-1:0] paddr,
	input  logic [irpd_pkg::APB_DW-1:0] pwdata,
	output logic [irpd_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	irpd_in_if.sink                     evt,
	input  logic                        q_full,
	output logic                        push,
	output irpd_pkg::cls_t              push_word
);
	import irpd_pkg::*;

	logic [CFG_W-1:0]  lead_min_q, lead_max_q, space_min_q, space_max_q;
	logic [CFG_W-1:0]  rep_min_q, rep_max_q, short_min_q, short_max_q;
	logic              wr_en;
	reg_idx_t          idx;
	logic [CFG_W-1:0]  rd_val;
	logic [TIME_W-1:0] dur_ext, w;

	function automatic logic in_win(input logic [TIME_W-1:0] v,
		input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
		return (v >= lo) && (v < hi);
	endfunction

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_min_q  <= LEAD_MIN_RST;
			lead_max_q  <= LEAD_MAX_RST;
			space_min_q <= SPACE_MIN_RST;
			space_max_q <= SPACE_MAX_RST;
			rep_min_q   <= REP_MIN_RST;
			rep_max_q   <= REP_MAX_RST;
			short_min_q <= SHORT_MIN_RST;
			short_max_q <= SHORT_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_LEAD_MIN:  lead_min_q  <= pwdata[CFG_W-1:0];
				REG_LEAD_MAX:  lead_max_q  <= pwdata[CFG_W-1:0];
				REG_SPACE_MIN: space_min_q <= pwdata[CFG_W-1:0];
				REG_SPACE_MAX: space_max_q <= pwdata[CFG_W-1:0];
				REG_REP_MIN:   rep_min_q   <= pwdata[CFG_W-1:0];
				REG_REP_MAX:   rep_max_q   <= pwdata[CFG_W-1:0];
				REG_SHORT_MIN: short_min_q <= pwdata[CFG_W-1:0];
				REG_SHORT_MAX: short_max_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LEAD_MIN:  rd_val = lead_min_q;
			REG_LEAD_MAX:  rd_val = lead_max_q;
			REG_SPACE_MIN: rd_val = space_min_q;
			REG_SPACE_MAX: rd_val = space_max_q;
			REG_REP_MIN:   rd_val = rep_min_q;
			REG_REP_MAX:   rd_val = rep_max_q;
			REG_SHORT_MIN: rd_val = short_min_q;
			REG_SHORT_MAX: rd_val = short_max_q;
			default:       rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_DW-CFG_W){1'b0}}, rd_val};

	// classification
	assign dur_ext = {{(TIME_W-DUR_W){1'b0}}, evt.duration};
	assign w       = (dur_ext > TICK_LIMIT) ? TICK_LIMIT : dur_ext;

	assign evt.ready = !q_full;
	assign push      = evt.valid && !q_full;

	always_comb begin
		push_word.clear    = evt.req_type;
		push_word.zero     = (w == '0);
		push_word.lead_ok  = in_win(w, {1'b0, lead_min_q}, {1'b0, lead_max_q});
		push_word.space_ok = in_win(w, {1'b0, space_min_q}, {1'b0, space_max_q});
		push_word.rep_ok   = in_win(w, {1'b0, rep_min_q}, {1'b0, rep_max_q});
		push_word.short_ok = in_win(w, {1'b0, short_min_q}, {1'b0, short_max_q});
		push_word.long_ok  = in_win(w, LONG_MIN_US, LONG_MAX_US);
	end

endmodule

/* hw/rtl/irpd_queue.sv */
// ---------------------------------------------------------------------------
// irpd_queue
// Short FIFO of classified edge words between front and back.
// ---------------------------------------------------------------------------
module irpd_queue #(
	parameter int unsigned DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  irpd_pkg::cls_t push_word,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output irpd_pkg::cls_t head
);
	import irpd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cls_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= nxt(wp_q);
			end
			if (pop) begin
				rp_q <= nxt(rp_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/irpd_back.sv */
// ---------------------------------------------------------------------------
// irpd_back
// Frame sequencer: walks lead, space, marks and bit spaces, keeps the frame
// and the flags, and holds the result word in an output register.
// ---------------------------------------------------------------------------
module irpd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  irpd_pkg::cls_t head,
	output logic           pop,
	irpd_out_if.source     res
);
	import irpd_pkg::*;

	phase_t              ph_q, ph_d;
	logic [BITS_W-1:0]   bits_q, bits_d;
	logic [WORD_W-1:0]   shift_q, shift_d;
	logic [WORD_W-1:0]   frame_q, frame_d;
	logic                rep_q, rep_d;
	logic                cmpl_q, cmpl_d;
	logic                active;
	logic                ov_q;
	logic                o_cmpl_q, o_rep_q, o_recv_q;
	logic [BYTE_W-1:0]   o_addr_q, o_cmd_q;

	assign pop    = q_valid && (!ov_q || res.ready);
	assign active = (ph_q == PH_LEAD) || (ph_q == PH_SPACE) ||
		(ph_q == PH_MARK) || (ph_q == PH_BIT);

	always_comb begin
		ph_d    = ph_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		frame_d = frame_q;
		rep_d   = rep_q;
		cmpl_d  = cmpl_q;
		if (head.clear) begin
			rep_d  = 1'b0;
			cmpl_d = 1'b0;
		end else if (!active || !head.zero) begin
			unique case (ph_q)
				PH_LEAD: begin
					if (head.lead_ok) begin
						ph_d = PH_SPACE;
					end else begin
						ph_d   = PH_IDLE;
						bits_d = '0;
					end
				end
				PH_SPACE: begin
					if (head.space_ok) begin
						ph_d = PH_MARK;
					end else if (head.rep_ok) begin
						rep_d = 1'b1;
						ph_d  = PH_MARK;
					end else begin
						ph_d   = PH_IDLE;
						bits_d = '0;
					end
				end
				PH_MARK: begin
					if (!head.short_ok) begin
						ph_d   = PH_IDLE;
						bits_d = '0;
					end else if (bits_q < BITS_W'(FRAME_BITS) && !rep_q) begin
						ph_d = PH_BIT;
					end else begin
						if (rep_q) begin
							cmpl_d = 1'b1;
						end else begin
							frame_d = shift_q;
							if (shift_q[7:0] == ~shift_q[15:8] &&
								shift_q[23:16] == ~shift_q[31:24]) begin
								cmpl_d = 1'b1;
							end
						end
						ph_d   = PH_IDLE;
						bits_d = '0;
					end
				end
				PH_BIT: begin
					if (head.short_ok || head.long_ok) begin
						shift_d[bits_q[4:0]] = !head.short_ok;
						bits_d = bits_q + 1'b1;
						ph_d   = PH_MARK;
					end else begin
						ph_d   = PH_IDLE;
						bits_d = '0;
					end
				end
				default: begin
					bits_d = '0;
					ph_d   = PH_LEAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			bits_q  <= '0;
			shift_q <= '0;
			frame_q <= '0;
			rep_q   <= 1'b0;
			cmpl_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (pop) begin
				ph_q    <= ph_d;
				bits_q  <= bits_d;
				shift_q <= shift_d;
				frame_q <= frame_d;
				rep_q   <= rep_d;
				cmpl_q  <= cmpl_d;
				ov_q    <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			o_cmpl_q <= cmpl_d;
			o_rep_q  <= rep_d;
			o_addr_q <= frame_d[7:0];
			o_cmd_q  <= frame_d[23:16];
			o_recv_q <= (ph_d != PH_IDLE);
		end
	end

	assign res.valid          = ov_q;
	assign res.frame_complete = o_cmpl_q;
	assign res.repeat_seen    = o_rep_q;
	assign res.address        = o_addr_q;
	assign res.command        = o_cmd_q;
	assign res.receiving      = o_recv_q;

endmodule

/* hw/rtl/ir_remote_pulse_decoder_core.sv */
// ---------------------------------------------------------------------------
// ir_remote_pulse_decoder_core
// NEC-style IR frame decoder driven by edge-width words.
//
//   channel  dir  payload                                          handshake
//   evt      in   req_type, duration                               valid/ready
//   res      out  frame_complete, repeat_seen, address, command,   valid/ready
//                 receiving
//   apb      in   8 x 15-bit window registers at 4*i               psel/penable
//
// One word per cycle sustained while res.ready holds; a word is classified and
// written to the queue at the edge that takes it, and the sequencer step pops
// it into the output register, so the result reaches res through the queue and
// the output register. Throughput is set by the sequencer step in the back end.
// While a result waits on res.ready the queue fills to QUEUE_DEPTH words (two by
// default), then evt.ready drops.
// Asynchronous active-low reset clears the phase, frame and flags; registers
// return to their default windows.
// ---------------------------------------------------------------------------
module ir_remote_pulse_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [irpd_pkg::APB_AW-1:0] paddr,
	input  logic [irpd_pkg::APB_DW-1:0] pwdata,
	output logic [irpd_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	irpd_in_if.sink                     evt,
	irpd_out_if.source                  res
);
	import irpd_pkg::*;

	logic q_full, push, pop, q_valid;
	cls_t push_word, head;

	irpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.evt       (evt),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	irpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (head)
	);

	irpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.res     (res)
	);

endmodule

/* hw/rtl/irpd_checker.sv */
// ---------------------------------------------------------------------------
// irpd_checker
// Port-level checks of the IR remote pulse decoder, bound to the core.
// ---------------------------------------------------------------------------
module irpd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [irpd_pkg::APB_AW-1:0] paddr,
	input logic [irpd_pkg::APB_DW-1:0] pwdata,
	input logic [irpd_pkg::APB_DW-1:0] prdata,
	input logic                        pready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        res_frame_complete,
	input logic                        res_repeat_seen,
	input logic [irpd_pkg::BYTE_W-1:0] res_address,
	input logic [irpd_pkg::BYTE_W-1:0] res_command,
	input logic                        res_receiving
);
	import irpd_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({res_frame_complete, res_repeat_seen,
			res_address, res_command, res_receiving}))
		else $error("result word changed while stalled");

	a_apb_rd_shape: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[APB_DW-1:CFG_W] == '0))
		else $error("pready low or register read has stray upper bits");

	a_apb_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite) && (paddr[4:2] == $past(paddr[4:2]))
		|-> (prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0])))
		else $error("register readback differs from last write");

endmodule

bind ir_remote_pulse_decoder_core irpd_checker u_irpd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.psel               (psel),
	.penable            (penable),
	.pwrite             (pwrite),
	.paddr              (paddr),
	.pwdata             (pwdata),
	.prdata             (prdata),
	.pready             (pready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_frame_complete (res.frame_complete),
	.res_repeat_seen    (res.repeat_seen),
	.res_address        (res.address),
	.res_command        (res.command),
	.res_receiving      (res.receiving)
);

/* sim/ir_remote_pulse_decoder_core_tb.sv */
// ---------------------------------------------------------------------------
// ir_remote_pulse_decoder_core_tb
// Self-checking bench for the IR pulse decoder core. Edge and clear words go
// in on the evt channel, and a behavioral decoder predicts the status word
// for each one. Every status word on res is checked in order. Window
// registers are set over APB and read back while the core is idle. Traffic
// is directed boundary cases first, then random NEC frames, repeat frames,
// broken frames and noise. This runs under several window settings and
// idling mixes, plus a long res stall and a full drain.
// ---------------------------------------------------------------------------
module ir_remote_pulse_decoder_core_tb;
	import irpd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic             frame_complete;
		logic             repeat_seen;
		logic [BYTE_W-1:0] address;
		logic [BYTE_W-1:0] command;
		logic             receiving;
	} ir_status_t;

	logic clk;
	logic arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	irpd_in_if  evt_ch();
	irpd_out_if res_ch();

	ir_remote_pulse_decoder_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	// decoder model state
	phase_t              cur_phase;
	logic [BITS_W-1:0]   bit_count;
	logic [WORD_W-1:0]   shift_reg;
	logic [WORD_W-1:0]   frame_reg;
	logic                rep_flag;
	logic                done_flag;
	logic [CFG_W-1:0]    window [8];

	ir_status_t status_q [$];
	ir_status_t got;
	ir_status_t want;

	int gap_pct;
	int stall_pct;
	int hold_left;
	int words_sent;
	int results_checked;
	int err_count;
	int frames_ok;
	int repeat_ends;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic logic in_win(input logic [TIME_W-1:0] w, input reg_idx_t lo_idx);
		return w >= {1'b0, window[lo_idx]} && w < {1'b0, window[lo_idx + 1]};
	endfunction

	function automatic ir_status_t decode_word(input logic req, input logic [DUR_W-1:0] dur);
		logic [TIME_W-1:0] w;
		ir_status_t st;
		w = ({1'b0, dur} > TICK_LIMIT) ? TICK_LIMIT : {1'b0, dur};
		if (req) begin
			done_flag = 1'b0;
			rep_flag = 1'b0;
		end else if (cur_phase == PH_IDLE) begin
			bit_count = '0;
			cur_phase = PH_LEAD;
		end else if (w != '0) begin
			case (cur_phase)
				PH_LEAD: begin
					cur_phase = in_win(w, REG_LEAD_MIN) ? PH_SPACE : PH_IDLE;
				end
				PH_SPACE: begin
					if (in_win(w, REG_SPACE_MIN)) begin
						cur_phase = PH_MARK;
					end else if (in_win(w, REG_REP_MIN)) begin
						rep_flag = 1'b1;
						cur_phase = PH_MARK;
					end else begin
						cur_phase = PH_IDLE;
					end
				end
				PH_MARK: begin
					if (!in_win(w, REG_SHORT_MIN)) begin
						cur_phase = PH_IDLE;
					end else if (bit_count < FRAME_BITS && !rep_flag) begin
						cur_phase = PH_BIT;
					end else begin
						if (rep_flag) begin
							done_flag = 1'b1;
							repeat_ends++;
						end else begin
							frame_reg = shift_reg;
							if (frame_reg[7:0] == ~frame_reg[15:8] &&
								frame_reg[23:16] == ~frame_reg[31:24]) begin
								done_flag = 1'b1;
								frames_ok++;
							end
						end
						cur_phase = PH_IDLE;
					end
				end
				PH_BIT: begin
					if (in_win(w, REG_SHORT_MIN)) begin
						shift_reg[bit_count[4:0]] = 1'b0;
						bit_count = bit_count + 1'b1;
						cur_phase = PH_MARK;
					end else if (w >= LONG_MIN_US && w < LONG_MAX_US) begin
						shift_reg[bit_count[4:0]] = 1'b1;
						bit_count = bit_count + 1'b1;
						cur_phase = PH_MARK;
					end else begin
						cur_phase = PH_IDLE;
					end
				end
				default: begin
					cur_phase = PH_IDLE;
				end
			endcase
			if (cur_phase == PH_IDLE) begin
				bit_count = '0;
			end
		end
		st.frame_complete = done_flag;
		st.repeat_seen = rep_flag;
		st.address = frame_reg[7:0];
		st.command = frame_reg[23:16];
		st.receiving = (cur_phase != PH_IDLE);
		return st;
	endfunction

	function automatic logic [DUR_W-1:0] pick_in(input reg_idx_t lo_idx);
		int lo;
		int hi;
		lo = window[lo_idx];
		hi = window[lo_idx + 1];
		return (hi > lo) ? DUR_W'($urandom_range(hi - 1, lo)) : DUR_W'(lo);
	endfunction

	// res.ready: random stalls, or a forced hold-off while hold_left runs down
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.frame_complete = res_ch.frame_complete;
			got.repeat_seen = res_ch.repeat_seen;
			got.address = res_ch.address;
			got.command = res_ch.command;
			got.receiving = res_ch.receiving;
			results_checked++;
			if (status_q.size() == 0) begin
				flag_error($sformatf("unexpected status word: fc=%0b rs=%0b adr=%02h cmd=%02h rx=%0b",
					got.frame_complete, got.repeat_seen, got.address, got.command,
					got.receiving));
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					flag_error($sformatf(
						"word %0d: exp fc=%0b rs=%0b adr=%02h cmd=%02h rx=%0b, got fc=%0b rs=%0b adr=%02h cmd=%02h rx=%0b",
						results_checked, want.frame_complete, want.repeat_seen, want.address,
						want.command, want.receiving, got.frame_complete, got.repeat_seen,
						got.address, got.command, got.receiving));
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d status words outstanding", CYCLE_LIMIT,
			status_q.size());
		$display("CHECK FAILED");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input logic req, input logic [DUR_W-1:0] dur);
		while ($urandom_range(0, 99) < gap_pct) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.req_type <= req;
		evt_ch.duration <= dur;
		do @(posedge clk); while (!evt_ch.ready);
		status_q.push_back(decode_word(req, dur));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results();
		evt_ch.valid <= 1'b0;
		while (status_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_set(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		logic [APB_DW-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {17'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		window[idx] = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (rd !== {{(APB_DW - CFG_W){1'b0}}, val}) begin
			flag_error($sformatf("register %s: read %08h, expected %08h", idx.name(), rd,
				{{(APB_DW - CFG_W){1'b0}}, val}));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_windows(input int lead_lo, input int lead_hi, input int sp_lo,
		input int sp_hi, input int rep_lo, input int rep_hi, input int sh_lo, input int sh_hi);
		wait_results();
		cfg_set(REG_LEAD_MIN, CFG_W'(lead_lo));
		cfg_set(REG_LEAD_MAX, CFG_W'(lead_hi));
		cfg_set(REG_SPACE_MIN, CFG_W'(sp_lo));
		cfg_set(REG_SPACE_MAX, CFG_W'(sp_hi));
		cfg_set(REG_REP_MIN, CFG_W'(rep_lo));
		cfg_set(REG_REP_MAX, CFG_W'(rep_hi));
		cfg_set(REG_SHORT_MIN, CFG_W'(sh_lo));
		cfg_set(REG_SHORT_MAX, CFG_W'(sh_hi));
	endtask

	// cut > 0 replaces that edge with a random width and drops the rest
	task automatic send_frame(input bit is_repeat, input int cut);
		logic [DUR_W-1:0] edges [$];
		logic [7:0] adr;
		logic [7:0] cmd;
		logic [WORD_W-1:0] bits;
		adr = 8'($urandom);
		cmd = 8'($urandom);
		bits = ($urandom_range(0, 99) < 80) ? {~cmd, cmd, ~adr, adr} : WORD_W'($urandom);
		edges.push_back(DUR_W'($urandom_range(0, 32767)));
		edges.push_back(pick_in(REG_LEAD_MIN));
		edges.push_back(pick_in(is_repeat ? REG_REP_MIN : REG_SPACE_MIN));
		if (!is_repeat) begin
			for (int i = 0; i < FRAME_BITS; i++) begin
				edges.push_back(pick_in(REG_SHORT_MIN));
				edges.push_back(bits[i] ? DUR_W'($urandom_range(LONG_MAX_US - 1, LONG_MIN_US))
					: pick_in(REG_SHORT_MIN));
			end
		end
		edges.push_back(pick_in(REG_SHORT_MIN));
		if (cut > 0 && cut < edges.size()) begin
			edges[cut] = DUR_W'($urandom_range(1, 32767));
			while (edges.size() > cut + 1) void'(edges.pop_back());
		end
		foreach (edges[i]) begin
			if ($urandom_range(0, 99) < 3) begin
				send_word(1'b0, '0);
			end
			send_word(1'b0, edges[i]);
		end
	endtask

	task automatic run_random(input int n);
		int stop_at;
		int r;
		stop_at = words_sent + n;
		while (words_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_frame(1'b0, 0);
			end else if (r < 62) begin
				send_frame(1'b1, 0);
			end else if (r < 80) begin
				send_frame(1'($urandom_range(0, 1)), $urandom_range(1, 67));
			end else if (r < 90) begin
				send_word(1'b1, DUR_W'($urandom));
			end else begin
				send_word(1'b0, DUR_W'($urandom));
			end
			// no clear now and then, so a stale repeat flag carries into the next frame
			if (r < 80 && $urandom_range(0, 99) < 60) begin
				send_word(1'b1, DUR_W'($urandom));
			end
		end
	endtask

	task automatic test_directed_edges();
		gap_pct = 0;
		stall_pct = 0;
		send_word(1'b1, 15'h7fff);
		send_word(1'b0, 15'd0);
		send_word(1'b0, 15'd0);
		send_word(1'b0, 15'h7fff);
		// repeat frame at the low window edges
		send_word(1'b0, 15'd123);
		send_word(1'b0, 15'd8200);
		send_word(1'b0, 15'd2100);
		send_word(1'b0, 15'd450);
		// full space with repeat still flagged ends as a repeat
		send_word(1'b0, 15'd5);
		send_word(1'b0, 15'd9499);
		send_word(1'b0, 15'd4599);
		send_word(1'b0, 15'd599);
		send_word(1'b1, 15'd0);
		// mark at the exclusive upper bound
		send_word(1'b0, 15'd1);
		send_word(1'b0, 15'd8200);
		send_word(1'b0, 15'd4200);
		send_word(1'b0, 15'd600);
		// long bit edges
		send_word(1'b0, 15'd1);
		send_word(1'b0, 15'd9000);
		send_word(1'b0, 15'd4400);
		send_word(1'b0, 15'd500);
		send_word(1'b0, 15'd1999);
		send_word(1'b0, 15'd500);
		send_word(1'b0, 15'd2000);
		// space in neither window
		send_word(1'b0, 15'd1);
		send_word(1'b0, 15'd8200);
		send_word(1'b0, 15'd4600);
	endtask

	task automatic test_random_stream();
		gap_pct = 0;
		stall_pct = 0;
		run_random(300);
	endtask

	task automatic test_overlapping_windows();
		set_windows(8000, 9000, 3000, 5000, 2000, 4000, 450, 1500);
		gap_pct = 66;
		stall_pct = 0;
		run_random(250);
	endtask

	task automatic test_open_windows();
		set_windows(0, 30000, 0, 30000, 0, 30000, 0, 30000);
		gap_pct = 0;
		stall_pct = 66;
		run_random(200);
	endtask

	task automatic test_closed_windows();
		set_windows(0, 0, 0, 0, 0, 0, 0, 0);
		gap_pct = 14;
		stall_pct = 14;
		run_random(80);
	endtask

	task automatic test_random_windows();
		int lead_lo;
		int sp_lo;
		int rep_lo;
		int sh_lo;
		for (int k = 0; k < 3; k++) begin
			lead_lo = $urandom_range(6000, 9000);
			sp_lo = $urandom_range(3000, 5000);
			rep_lo = $urandom_range(1500, 3000);
			sh_lo = $urandom_range(200, 700);
			set_windows(lead_lo, lead_lo + $urandom_range(0, 3000), sp_lo,
				sp_lo + $urandom_range(100, 1500), rep_lo, rep_lo + $urandom_range(100, 1000),
				sh_lo, sh_lo + $urandom_range(100, 800));
			gap_pct = 14;
			stall_pct = 14;
			run_random(100);
		end
	endtask

	task automatic test_backpressure();
		set_windows(LEAD_MIN_RST, LEAD_MAX_RST, SPACE_MIN_RST, SPACE_MAX_RST, REP_MIN_RST,
			REP_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST);
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 80;
		send_frame(1'b0, 0);
		wait_results();
		gap_pct = 14;
		stall_pct = 14;
		run_random(60);
	endtask

	initial begin
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.req_type = 1'b0;
		evt_ch.duration = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		words_sent = 0;
		results_checked = 0;
		err_count = 0;
		frames_ok = 0;
		repeat_ends = 0;
		cur_phase = PH_IDLE;
		bit_count = '0;
		shift_reg = '0;
		frame_reg = '0;
		rep_flag = 1'b0;
		done_flag = 1'b0;
		window[REG_LEAD_MIN] = LEAD_MIN_RST;
		window[REG_LEAD_MAX] = LEAD_MAX_RST;
		window[REG_SPACE_MIN] = SPACE_MIN_RST;
		window[REG_SPACE_MAX] = SPACE_MAX_RST;
		window[REG_REP_MIN] = REP_MIN_RST;
		window[REG_REP_MAX] = REP_MAX_RST;
		window[REG_SHORT_MIN] = SHORT_MIN_RST;
		window[REG_SHORT_MAX] = SHORT_MAX_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_edges();
		test_random_stream();
		test_overlapping_windows();
		test_open_windows();
		test_closed_windows();
		test_random_windows();
		test_backpressure();

		wait_results();
		repeat (8) @(negedge clk);
		$display("Sent %0d words over default, overlapping, open, closed and random windows,",
			words_sent);
		$display("%0d status words checked, %0d good frames and %0d repeat ends decoded",
			results_checked, frames_ok, repeat_ends);
		if (err_count == 0 && status_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d errors", err_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
